@@ hdl/dtd_pkg.sv @@
// Shared types and constants for the date text to day number block.
package dtd_pkg;

	// Character codes recognized by the parser.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result error codes.
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_SHORT  = 2'd1;
	localparam logic [1:0] ERR_FIELDS = 2'd2;
	localparam logic [1:0] ERR_CHAR   = 2'd3;

	// Shortest string that can give a valid date, and the saturating count limit.
	localparam logic [2:0] MIN_LENGTH = 3'd5;

	// Field indexes.
	localparam logic [1:0] FLD_YEAR  = 2'd0;
	localparam logic [1:0] FLD_MONTH = 2'd1;
	localparam logic [1:0] FLD_DAY   = 2'd2;

	// Day count arithmetic constants.
	localparam logic [31:0] YEAR_SHIFT  = 32'd4800;
	localparam logic [31:0] DAY_BIAS    = 32'h8000_0000 - 32'd2472633;
	// Reciprocals for exact unsigned division of 31-bit values.
	localparam logic [30:0] RECIP_100   = 31'd1374389535;
	localparam int          RSHIFT_100  = 37;
	localparam logic [31:0] RECIP_5     = 32'd3435973837;
	localparam int          RSHIFT_5    = 34;

	localparam int QUEUE_DEPTH = 2;

	// One parsed date handed from the parser to the day count pipeline.
	typedef struct packed {
		logic [31:0] year;
		logic [31:0] month;
		logic [31:0] day;
		logic        year_neg;
		logic [1:0]  err;
	} date_entry_t;

endpackage

@@ hdl/dtd_front.sv @@
// Character parser: accumulates year, month and day and classifies errors.
module dtd_front
	import dtd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        push_valid,
	input  logic        push_ready,
	output date_entry_t push_data
);

	logic [31:0] field_q [3];
	logic [1:0]  field_index_q;
	logic        year_neg_q;
	logic [2:0]  char_count_q;
	logic [1:0]  latched_error_q;

	logic [31:0] field_nxt [3];
	logic [1:0]  index_nxt;
	logic        neg_nxt;
	logic [2:0]  count_nxt;
	logic [1:0]  err_nxt;
	logic [1:0]  sel;
	logic [3:0]  digit;
	logic        is_digit;
	logic        first;
	logic        accept;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign push_valid = in_valid && last_char;

	always_comb begin
		first     = (char_count_q == 3'd0);
		count_nxt = (char_count_q < MIN_LENGTH) ? char_count_q + 3'd1 : char_count_q;
		is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		digit     = 4'(char_code - CH_ZERO);
		sel       = (field_index_q == 2'd3) ? FLD_DAY : field_index_q;
		field_nxt = field_q;
		index_nxt = field_index_q;
		neg_nxt   = year_neg_q;
		err_nxt   = latched_error_q;
		// Once an error is latched the fields are frozen.
		if (latched_error_q == ERR_NONE) begin
			if (char_code == CH_MINUS) begin
				if (first) begin
					neg_nxt = 1'b1;
				end else if (field_index_q >= FLD_DAY) begin
					err_nxt = ERR_FIELDS;
				end else begin
					index_nxt = field_index_q + 2'd1;
				end
			end else if (is_digit) begin
				field_nxt[sel] = (field_q[sel] << 3) + (field_q[sel] << 1) + {28'd0, digit};
			end else begin
				err_nxt = ERR_CHAR;
			end
		end
		push_data.year     = field_nxt[FLD_YEAR];
		push_data.month    = field_nxt[FLD_MONTH];
		push_data.day      = field_nxt[FLD_DAY];
		push_data.year_neg = neg_nxt;
		push_data.err      = (count_nxt < MIN_LENGTH) ? ERR_SHORT : err_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q         <= '{default: '0};
			field_index_q   <= FLD_YEAR;
			year_neg_q      <= 1'b0;
			char_count_q    <= 3'd0;
			latched_error_q <= ERR_NONE;
		end else if (accept) begin
			if (last_char) begin
				field_q         <= '{default: '0};
				field_index_q   <= FLD_YEAR;
				year_neg_q      <= 1'b0;
				char_count_q    <= 3'd0;
				latched_error_q <= ERR_NONE;
			end else begin
				field_q         <= field_nxt;
				field_index_q   <= index_nxt;
				year_neg_q      <= neg_nxt;
				char_count_q    <= count_nxt;
				latched_error_q <= err_nxt;
			end
		end
	end

	a_string_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_char |=> char_count_q == 3'd0 && latched_error_q == ERR_NONE
			&& field_index_q == FLD_YEAR)
		else $error("parser state not cleared after the last word of a string");

endmodule

@@ hdl/dtd_queue.sv @@
// Short queue of parsed dates between the parser and the day count pipeline.
module dtd_queue
	import dtd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  date_entry_t push_data,
	output logic        pop_valid,
	input  logic        pop_ready,
	output date_entry_t pop_data
);

	localparam int IdxW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	date_entry_t mem_q [DEPTH];
	logic [IdxW-1:0] wr_ptr_q;
	logic [IdxW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CntW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue occupancy beyond its depth");

endmodule

@@ hdl/dtd_back.sv @@
// Day count pipeline: four stages from a parsed date to the biased day number.
module dtd_back
	import dtd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  date_entry_t pop_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] day_value,
	output logic [1:0]  error_code
);

	logic en;

	// Stage 1: signed year, March-based year and month, month term.
	logic        valid_s1;
	logic [31:0] y_s1;
	logic [31:0] t_s1;
	logic [31:0] day_s1;
	logic [1:0]  err_s1;

	// Stage 2: reciprocal products and the year times 365 term.
	logic        valid_s2;
	logic [31:0] y_s2;
	logic        yneg_s2;
	logic        tneg_s2;
	logic [24:0] q100_s2;
	logic [28:0] q5_s2;
	logic [31:0] y365_s2;
	logic [31:0] day_s2;
	logic [1:0]  err_s2;

	// Stage 3: two partial sums.
	logic        valid_s3;
	logic [31:0] sum_a_s3;
	logic [31:0] sum_b_s3;
	logic [1:0]  err_s3;

	logic [31:0] day_value_q;
	logic [1:0]  error_code_q;
	logic        out_valid_q;

	logic [31:0] year_c;
	logic        early_c;
	logic [31:0] m_c;
	logic [30:0] uy_c;
	logic [30:0] ut_c;
	logic [61:0] py_c;
	logic [62:0] pt_c;
	logic [31:0] f100_c;
	logic [31:0] f5_c;
	logic [31:0] f4_c;
	logic [31:0] f400_c;

	// The whole pipeline moves together unless the output word is held.
	assign en        = !out_valid_q || out_ready;
	assign pop_ready = en;

	always_comb begin
		year_c  = pop_data.year_neg ? 32'd0 - pop_data.year : pop_data.year;
		early_c = (pop_data.month == 32'd1) || (pop_data.month == 32'd2);
		m_c     = pop_data.month + (early_c ? 32'd12 : 32'd0) - 32'd3;
	end

	// Floor division of a negative value a by d is ~(~a / d), so the dividers
	// only ever see 31-bit non-negative operands.
	always_comb begin
		uy_c = y_s1[31] ? ~y_s1[30:0] : y_s1[30:0];
		ut_c = t_s1[31] ? ~t_s1[30:0] : t_s1[30:0];
		py_c = 62'(uy_c) * 62'(RECIP_100);
		pt_c = 63'(ut_c) * 63'(RECIP_5);
	end

	always_comb begin
		f100_c = yneg_s2 ? ~{7'd0, q100_s2} : {7'd0, q100_s2};
		f5_c   = tneg_s2 ? ~{3'd0, q5_s2} : {3'd0, q5_s2};
		f4_c   = 32'($signed(y_s2) >>> 2);
		f400_c = 32'($signed(f100_c) >>> 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1   <= year_c + YEAR_SHIFT - {31'd0, early_c};
			t_s1   <= (m_c << 7) + (m_c << 4) + (m_c << 3) + m_c + 32'd2;
			day_s1 <= pop_data.day;
			err_s1 <= pop_data.err;

			y_s2    <= y_s1;
			yneg_s2 <= y_s1[31];
			tneg_s2 <= t_s1[31];
			q100_s2 <= py_c[RSHIFT_100 +: 25];
			q5_s2   <= pt_c[RSHIFT_5 +: 29];
			y365_s2 <= (y_s1 << 8) + (y_s1 << 6) + (y_s1 << 5) + (y_s1 << 3)
				+ (y_s1 << 2) + y_s1;
			day_s2  <= day_s1;
			err_s2  <= err_s1;

			sum_a_s3 <= DAY_BIAS + day_s2 + f5_c + y365_s2;
			sum_b_s3 <= f4_c + f400_c - f100_c;
			err_s3   <= err_s2;

			day_value_q  <= (err_s3 == ERR_NONE) ? sum_a_s3 + sum_b_s3 : 32'd0;
			error_code_q <= err_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign day_value  = day_value_q;
	assign error_code = error_code_q;

	a_error_zero_day: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_code_q != ERR_NONE |-> day_value_q == 32'd0)
		else $error("error word carries a nonzero day value");

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s3 |=> out_valid_q)
		else $error("last pipeline stage lost its word");

endmodule

@@ hdl/date_text_to_day_number_core.sv @@
// Top level of the date text to day number block.
//
// Input channel (in_valid/in_ready): one character word per cycle, char_code
// with last_char high on the final character of a date string "[-]Y-M-D".
// Output channel (out_valid/out_ready): one word per string, day_value (the
// Julian day number plus 2^31 - 2440588, modulo 2^32) and error_code (0 ok,
// 1 too short, 2 too many fields, 3 bad character; day_value is 0 on error).
// The parser takes one character every cycle while in_ready is high. After
// its last character is accepted, a string's result passes through the queue
// between parser and pipeline, then the three stages and the output register
// of the day count pipeline, whose depth its reciprocal multipliers set.
// The pipeline delivers one word per cycle while out_ready is high, so a new
// string may start the cycle after the previous one ends.
// When the receiver stalls, the pipeline holds, the queue fills, and then
// in_ready drops; no word is lost. Reset clears the parser state, empties
// the queue and the pipeline; the block takes characters right after reset.
module date_text_to_day_number_core
	import dtd_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] day_value,
	output logic [1:0]  error_code
);

	logic        push_valid;
	logic        push_ready;
	date_entry_t push_data;
	logic        pop_valid;
	logic        pop_ready;
	date_entry_t pop_data;

	dtd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.last_char  (last_char),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	dtd_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dtd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.day_value  (day_value),
		.error_code (error_code)
	);

endmodule
